[src/rab_pkg.sv]
package rab_pkg;

  // Screen geometry and frame store size
  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Field widths
  localparam int PIX_W      = 16;
  localparam int COORD_W    = 12;
  localparam int POS_W      = 14;
  localparam int SCR_COORD_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ALPHA_W    = 8;

  // Item modes
  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_ORIGIN_X = 3'd0,
    REG_DEST_ORIGIN_Y = 3'd1,
    REG_WINDOW_LEFT   = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5,
    REG_BLEND_ALPHA   = 3'd6
  } cfg_reg_t;

  // Channel expansion: v*255/31 and v*255/63 by scaled reciprocal
  localparam int EXP_SHIFT = 22;
  localparam int EXP5_MUL  = 34501755;  // 255 * ceil(2^22/31)
  localparam int EXP6_MUL  = 16977135;  // 255 * ceil(2^22/63)

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [30:0] prod;
    prod = 31'(v) * 31'(EXP5_MUL);
    return prod[EXP_SHIFT+7:EXP_SHIFT];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [30:0] prod;
    prod = 31'(v) * 31'(EXP6_MUL);
    return prod[EXP_SHIFT+7:EXP_SHIFT];
  endfunction

  // Exact floor(x/255) for the blend sums, which stay below 2^14
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [14:0] t;
    t = 15'(x) + 15'(x[13:8]) + 15'd1;
    return t[13:8];
  endfunction

  // One channel of (s*a + d*(255-a)) / 255
  function automatic logic [5:0] mix_chan(input logic [5:0] s, input logic [5:0] d,
                                          input logic [ALPHA_W-1:0] a);
    logic [13:0] sum;
    sum = 14'(s) * 14'(a) + 14'(d) * 14'(8'd255 - a);
    return div255(sum);
  endfunction

endpackage

[src/rgb565_alpha_blit_engine_top.sv]
// RGB565 alpha-blend blitter over a SCREEN_WIDTH x SCREEN_HEIGHT frame store. After
// reset the block sweeps the frame store to zero, one entry per cycle; in_ready stays
// low until the sweep is done, while cfg writes are taken at any time. After that it
// takes one word per cycle while the output is not stalled and returns one result word
// per input word, in order; an accepted word passes through the stage 1, stage 2 and
// stage 3 registers and then the output register, which raises out_valid. Each word does
// one read-modify-write of the single frame store memory (one write and one registered
// read port per cycle); words that touch the same pixel back to back are served by
// forwarding the pending write, so no stall is ever inserted. Blend words outside the
// window or landing off screen, and reads off screen, return all zero with landed low.
module rgb565_alpha_blit_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [rab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rab_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [rab_pkg::PIX_W-1:0]      in_source_pixel,
  input  logic [rab_pkg::COORD_W-1:0]    in_column,
  input  logic [rab_pkg::COORD_W-1:0]    in_line,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rab_pkg::PIX_W-1:0]      out_pixel_value,
  output logic [7:0]                     out_red_eight,
  output logic [7:0]                     out_green_eight,
  output logic [7:0]                     out_blue_eight,
  output logic                           out_landed
);

  import rab_pkg::*;

  // Configuration registers
  logic signed [COORD_W-1:0] dest_x_r, dest_y_r;
  logic [COORD_W-1:0]        win_left_r, win_top_r;
  logic [CFG_DATA_W-1:0]     win_width_r, win_height_r;
  logic [ALPHA_W-1:0]        alpha_r;

  // Clearing sweep
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Pipeline
  logic adv;
  logic p1_valid_r, p2_valid_r, p3_valid_r;
  logic p1_mode_r, p2_mode_r, p3_mode_r;
  logic [PIX_W-1:0] p1_src_r, p2_src_r, p3_src_r;
  logic signed [POS_W-1:0] p1_offx_r, p1_offy_r, p1_dx_r, p1_dy_r;
  logic p2_hit_r, p3_hit_r;
  logic [ADDR_W-1:0] p2_addr_r, p3_addr_r;
  logic [PIX_W-1:0] p3_dst_r;

  // Last write, for same-edge read hazards
  logic              wb_valid_r;
  logic [ADDR_W-1:0] wb_addr_r;
  logic [PIX_W-1:0]  wb_data_r;

  // Output register
  logic             out_valid_r, out_landed_r;
  logic [PIX_W-1:0] out_pixel_r;

  // Combinational
  logic signed [POS_W-1:0] acc_offx, acc_offy, acc_dx, acc_dy;
  logic                    p1_win_ok, p1_scr_ok, p1_hit;
  logic [23:0]             p1_addr_calc;
  logic [ADDR_W-1:0]       p1_addr;
  logic [PIX_W-1:0]        ram_rdata, p2_dst;
  logic [PIX_W-1:0]        blend_px, p3_result;
  logic [5:0]              mix_r, mix_g, mix_b;
  logic                    blend_we;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [PIX_W-1:0]        ram_wdata;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !clr_active_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r     <= '0;
      dest_y_r     <= '0;
      win_left_r   <= '0;
      win_top_r    <= '0;
      win_width_r  <= 13'd4096;
      win_height_r <= 13'd4096;
      alpha_r      <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEST_ORIGIN_X: dest_x_r     <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_DEST_ORIGIN_Y: dest_y_r     <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_WINDOW_LEFT:   win_left_r   <= cfg_wdata[COORD_W-1:0];
        REG_WINDOW_TOP:    win_top_r    <= cfg_wdata[COORD_W-1:0];
        REG_WINDOW_WIDTH:  win_width_r  <= cfg_wdata;
        REG_WINDOW_HEIGHT: win_height_r <= cfg_wdata;
        REG_BLEND_ALPHA:   alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep the frame store to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // Accept stage: window offsets and destination coordinates
  always_comb begin
    acc_offx = $signed({2'b00, in_column}) - $signed({2'b00, win_left_r});
    acc_offy = $signed({2'b00, in_line}) - $signed({2'b00, win_top_r});
    if (in_mode == MODE_READ) begin
      acc_dx = $signed({2'b00, in_column});
      acc_dy = $signed({2'b00, in_line});
    end else begin
      acc_dx = acc_offx + POS_W'(dest_x_r);
      acc_dy = acc_offy + POS_W'(dest_y_r);
    end
  end

  // Stage 1: range checks and address, issue the read
  always_comb begin
    p1_win_ok = (p1_offx_r >= 0) && (p1_offy_r >= 0) &&
                (p1_offx_r < $signed({1'b0, win_width_r})) &&
                (p1_offy_r < $signed({1'b0, win_height_r}));
    p1_scr_ok = (p1_dx_r >= 0) && (p1_dy_r >= 0) &&
                (p1_dx_r < POS_W'(SCREEN_WIDTH)) && (p1_dy_r < POS_W'(SCREEN_HEIGHT));
    p1_hit    = p1_scr_ok && ((p1_mode_r == MODE_READ) || p1_win_ok);
    p1_addr_calc = 24'(p1_dy_r[SCR_COORD_W-1:0]) * 24'(SCREEN_WIDTH) +
                   24'(p1_dx_r[SCR_COORD_W-1:0]);
    p1_addr   = p1_addr_calc[ADDR_W-1:0];
  end

  // Stage 2: pick the freshest copy of the destination pixel
  always_comb begin
    if (p3_valid_r && p3_hit_r && (p3_mode_r == MODE_BLEND) && (p3_addr_r == p2_addr_r)) begin
      p2_dst = blend_px;
    end else if (wb_valid_r && (wb_addr_r == p2_addr_r)) begin
      p2_dst = wb_data_r;
    end else begin
      p2_dst = ram_rdata;
    end
  end

  // Stage 3: blend per channel and form the result
  always_comb begin
    mix_r = mix_chan({1'b0, p3_src_r[15:11]}, {1'b0, p3_dst_r[15:11]}, alpha_r);
    mix_g = mix_chan(p3_src_r[10:5], p3_dst_r[10:5], alpha_r);
    mix_b = mix_chan({1'b0, p3_src_r[4:0]}, {1'b0, p3_dst_r[4:0]}, alpha_r);
    blend_px = {mix_r[4:0], mix_g, mix_b[4:0]};
    if (!p3_hit_r) begin
      p3_result = '0;
    end else if (p3_mode_r == MODE_READ) begin
      p3_result = p3_dst_r;
    end else begin
      p3_result = blend_px;
    end
  end

  assign blend_we = adv && p3_valid_r && p3_hit_r && (p3_mode_r == MODE_BLEND);

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r  <= in_valid && in_ready;
      p2_valid_r  <= p1_valid_r;
      p3_valid_r  <= p2_valid_r;
      out_valid_r <= p3_valid_r;
    end
  end

  // Pipeline payload; hold everything while the output is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mode_r    <= in_mode;
      p1_src_r     <= in_source_pixel;
      p1_offx_r    <= acc_offx;
      p1_offy_r    <= acc_offy;
      p1_dx_r      <= acc_dx;
      p1_dy_r      <= acc_dy;
      p2_mode_r    <= p1_mode_r;
      p2_src_r     <= p1_src_r;
      p2_hit_r     <= p1_hit;
      p2_addr_r    <= p1_addr;
      p3_mode_r    <= p2_mode_r;
      p3_src_r     <= p2_src_r;
      p3_hit_r     <= p2_hit_r;
      p3_addr_r    <= p2_addr_r;
      p3_dst_r     <= p2_dst;
      out_pixel_r  <= p3_result;
      out_landed_r <= p3_hit_r;
    end
  end

  // Remember the last blend write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (blend_we) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (blend_we) begin
      wb_addr_r <= p3_addr_r;
      wb_data_r <= blend_px;
    end
  end

  // Frame store write port: sweep first, then blend write-back
  always_comb begin
    if (clr_active_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = blend_we;
      ram_waddr = p3_addr_r;
      ram_wdata = blend_px;
    end
  end

  rab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (adv),
    .rd_addr (p1_addr),
    .rd_data (ram_rdata)
  );

  // Result word
  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_r;
  assign out_red_eight   = expand5(out_pixel_r[15:11]);
  assign out_green_eight = expand6(out_pixel_r[10:5]);
  assign out_blue_eight  = expand5(out_pixel_r[4:0]);
  assign out_landed      = out_landed_r;

  // No word enters while the sweep runs, and none is in flight
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!in_ready && !p1_valid_r && !p2_valid_r && !p3_valid_r))
    else $error("word in flight during frame store sweep");

  // A result that did not land carries a zero pixel
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_landed_r) |-> (out_pixel_r == '0))
    else $error("missed word returned nonzero pixel");

  // Full alpha reproduces the source exactly
  a_full_alpha_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (p3_valid_r && p3_hit_r && (p3_mode_r == MODE_BLEND) && (alpha_r == 8'd255))
      |-> (blend_px == p3_src_r))
    else $error("full alpha blend differs from source");

  // A write-back lands in the result register at the same edge
  a_write_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    blend_we |=> (out_valid_r && out_landed_r && (out_pixel_r == $past(ram_wdata))))
    else $error("write-back and result disagree");

endmodule

[src/rab_ram.sv]
module rab_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port; read port returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
